// ----- rtl/core/hlfr_pkg.sv -----
package hlfr_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned FRAME_W  = 17;
   localparam int unsigned TICK_W   = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 32;

   localparam logic [FRAME_W-1:0] HEADER_BYTES = FRAME_W'(4);

   localparam logic [BYTE_W-1:0]  FIRST_HDR_RESET  = '0;
   localparam logic [BYTE_W-1:0]  SECOND_HDR_RESET = '0;
   localparam logic [TICK_W-1:0]  TIMEOUT_RESET    = TICK_W'(1000);
   localparam logic [FRAME_W-1:0] MAX_FRAME_RESET  = FRAME_W'(65539);

   typedef enum logic [0:0] {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NO_HEADER = 2'd1,
      ST_BROKEN    = 2'd2,
      ST_TOO_LONG  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FIRST_HDR  = 2'd0,
      REG_SECOND_HDR = 2'd1,
      REG_TIMEOUT    = 2'd2,
      REG_MAX_FRAME  = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_LEN_LO  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_DRAIN   = 3'd5
   } phase_type;

endpackage

// ----- rtl/core/header_length_frame_receiver.sv -----
// A beat accepted on req_ waits in the input register and is processed once the
// result register is free; its result, if any, is registered there for rsp_.
// Throughput: one beat per clock, set by the single input register and the
// single result register; a stalled rsp_ holds the input stage.
// Reset (synchronous, active high): hunt for the first header, tick count
// cleared, registers back to their defaults, both stages empty.
module header_length_frame_receiver (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [7:0] rx_byte
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [hlfr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: [0] operation
   input  logic                               req_tuser,
   // rsp_tdata: [7:0] payload_byte, [24:8] frame_bytes, [31:25] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [hlfr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // rsp_tuser: [1:0] status
   output logic [hlfr_pkg::STATUS_W-1:0]      rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hlfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hlfr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import hlfr_pkg::*;

   // configuration
   logic [BYTE_W-1:0]  first_hdr_ff;
   logic [BYTE_W-1:0]  second_hdr_ff;
   logic [TICK_W-1:0]  timeout_ff;
   logic [FRAME_W-1:0] max_frame_ff;

   // input stage
   logic               in_valid_ff, in_valid_in;
   op_type             in_op_ff;
   logic [BYTE_W-1:0]  in_byte_ff;

   // frame state
   phase_type          phase_ff, phase_in;
   logic [TICK_W-1:0]  elapsed_ff, elapsed_in;
   logic [BYTE_W-1:0]  len_hi_ff, len_hi_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic [LEN_W-1:0]   total_ff, total_in;

   // result stage
   logic               out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               out_last_ff;
   status_type         out_status_ff;
   logic [FRAME_W-1:0] out_total_ff;

   logic               advance;
   logic [TICK_W-1:0]  tick_count;
   logic               timeout_hit;
   logic [LEN_W-1:0]   len_word;
   logic [FRAME_W-1:0] frame_len;
   logic               too_long;
   logic               len_zero;
   logic               last_byte;

   logic               res_valid;
   logic [BYTE_W-1:0]  res_byte;
   logic               res_last;
   status_type         res_status;
   logic [FRAME_W-1:0] res_total;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tvalid ? 1'b1 : (in_valid_ff && !advance);

   assign tick_count  = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TICK_W'(1);
   assign timeout_hit = tick_count >= timeout_ff;
   assign len_word    = {len_hi_ff, in_byte_ff};
   assign frame_len   = FRAME_W'(len_word) + HEADER_BYTES;
   assign too_long    = frame_len > max_frame_ff;
   assign len_zero    = (len_word == '0);
   assign last_byte   = (remain_ff == LEN_W'(1));

   // next frame state
   always_comb begin
      logic rearm;
      rearm      = 1'b0;
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      len_hi_in  = len_hi_ff;
      remain_in  = remain_ff;
      total_in   = total_ff;
      if (advance) begin
         if (in_op_ff == OP_TICK) begin
            elapsed_in = tick_count;
            rearm      = timeout_hit;
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  if (in_byte_ff == first_hdr_ff) phase_in = PH_HDR1;
               end
               PH_HDR1: begin
                  if (in_byte_ff != second_hdr_ff) rearm = 1'b1;
                  else phase_in = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  len_hi_in = in_byte_ff;
                  phase_in  = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  if (len_zero) begin
                     rearm = 1'b1;
                  end else if (too_long) begin
                     remain_in = len_word;
                     phase_in  = PH_DRAIN;
                  end else begin
                     remain_in = len_word;
                     total_in  = len_word;
                     phase_in  = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD, PH_DRAIN: begin
                  remain_in = remain_ff - LEN_W'(1);
                  rearm     = last_byte;
               end
               default: rearm = 1'b1;
            endcase
         end
      end
      if (rearm) begin
         phase_in   = PH_HUNT;
         elapsed_in = '0;
         len_hi_in  = '0;
         remain_in  = '0;
         total_in   = '0;
      end
   end

   // result for the beat in the input stage
   always_comb begin
      res_valid  = 1'b0;
      res_byte   = '0;
      res_last   = 1'b0;
      res_status = ST_OK;
      res_total  = '0;
      if (in_op_ff == OP_TICK) begin
         if (timeout_hit) begin
            res_valid = 1'b1;
            res_last  = 1'b1;
            case (phase_ff)
               PH_HUNT:  res_status = ST_NO_HEADER;
               PH_DRAIN: res_status = ST_TOO_LONG;
               default:  res_status = ST_BROKEN;
            endcase
         end
      end else begin
         case (phase_ff)
            PH_HDR1: begin
               if (in_byte_ff != second_hdr_ff) begin
                  res_valid  = 1'b1;
                  res_last   = 1'b1;
                  res_status = ST_BROKEN;
               end
            end
            PH_LEN_LO: begin
               if (len_zero) begin
                  res_valid = 1'b1;
                  res_last  = 1'b1;
                  if (too_long) res_status = ST_TOO_LONG;
                  else res_total = frame_len;
               end
            end
            PH_PAYLOAD: begin
               res_valid = 1'b1;
               res_byte  = in_byte_ff;
               if (last_byte) begin
                  res_last  = 1'b1;
                  res_total = FRAME_W'(total_ff) + HEADER_BYTES;
               end
            end
            PH_DRAIN: begin
               if (last_byte) begin
                  res_valid  = 1'b1;
                  res_last   = 1'b1;
                  res_status = ST_TOO_LONG;
               end
            end
            default: res_valid = 1'b0;
         endcase
      end
   end

   // a new result replaces one taken in the same cycle
   assign out_valid_in = advance ? res_valid : (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_hdr_ff  <= FIRST_HDR_RESET;
         second_hdr_ff <= SECOND_HDR_RESET;
         timeout_ff    <= TIMEOUT_RESET;
         max_frame_ff  <= MAX_FRAME_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_HUNT;
         elapsed_ff    <= '0;
         len_hi_ff     <= '0;
         remain_ff     <= '0;
         total_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_FIRST_HDR:  first_hdr_ff  <= csr_data[BYTE_W-1:0];
               REG_SECOND_HDR: second_hdr_ff <= csr_data[BYTE_W-1:0];
               REG_TIMEOUT:    timeout_ff    <= csr_data[TICK_W-1:0];
               REG_MAX_FRAME:  max_frame_ff  <= csr_data[FRAME_W-1:0];
               default:        max_frame_ff  <= max_frame_ff;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         len_hi_ff    <= len_hi_in;
         remain_ff    <= remain_in;
         total_ff     <= total_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= op_type'(req_tuser);
         in_byte_ff <= req_tdata[BYTE_W-1:0];
      end
      if (advance && res_valid) begin
         out_byte_ff   <= res_byte;
         out_last_ff   <= res_last;
         out_status_ff <= res_status;
         out_total_ff  <= res_total;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - BYTE_W - FRAME_W)'(0), out_total_ff, out_byte_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

endmodule
